// ===== design/bfgc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bfgc_pkg
// Shared codes, defaults and types of the bitmap filtered gather block.
// ----------------------------------------------------------------------------
package bfgc_pkg;

  localparam int INDEX_BITS_DEF  = 16;
  localparam int MAX_BATCH_DEF   = 65536;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int OP_BITS    = 2;
  localparam int DATA_BITS  = 32;
  localparam int IN_IDX_BITS = 16;
  localparam int LANE_OUT_BITS = 16;
  localparam int HIT_BITS   = 17;

  localparam logic [OP_BITS-1:0] OP_PROBE  = 2'd0;
  localparam logic [OP_BITS-1:0] OP_WR_BMP = 2'd1;
  localparam logic [OP_BITS-1:0] OP_WR_TBL = 2'd2;
  localparam logic [OP_BITS-1:0] OP_NOP    = 2'd3;

  localparam logic KIND_HIT     = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [HIT_BITS-1:0] HIT_MAX = 17'h1FFFF;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

// ===== design/bfgc_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bfgc_front
// Input register: accepts beats, drops NOP operations, feeds the queue.
// ----------------------------------------------------------------------------
module bfgc_front #(
  parameter int INDEX_BITS = bfgc_pkg::INDEX_BITS_DEF,
  parameter int Q_WIDTH    = INDEX_BITS + 35
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [bfgc_pkg::OP_BITS-1:0]        in_operation,
  input  wire logic [bfgc_pkg::IN_IDX_BITS-1:0]    in_index,
  input  wire logic [bfgc_pkg::DATA_BITS-1:0]      in_data,
  input  wire logic                                in_last_in_batch,
  input  wire bfgc_pkg::q_stat_t                   q_stat,
  output logic                                     q_push,
  output logic [Q_WIDTH-1:0]                       q_data
);

  logic                                  f_valid_r;
  logic [bfgc_pkg::OP_BITS-1:0]          f_op_r;
  logic [INDEX_BITS-1:0]                 f_idx_r;
  logic [bfgc_pkg::DATA_BITS-1:0]        f_data_r;
  logic                                  f_last_r;
  logic [INDEX_BITS+bfgc_pkg::IN_IDX_BITS-1:0] idx_ext;
  logic                                  accept;

  assign in_ready = !f_valid_r || !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign q_push   = f_valid_r && !q_stat.full;
  assign idx_ext  = {{INDEX_BITS{1'b0}}, in_index};
  assign q_data   = {f_op_r, f_last_r, f_data_r, f_idx_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (accept) begin
      f_valid_r <= (in_operation != bfgc_pkg::OP_NOP);
    end else if (q_push) begin
      f_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_op_r   <= in_operation;
      f_idx_r  <= idx_ext[INDEX_BITS-1:0];
      f_data_r <= in_data;
      f_last_r <= in_last_in_batch;
    end
  end

endmodule
`default_nettype wire

// ===== design/bfgc_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bfgc_queue
// Small register queue between the front and the back.
// ----------------------------------------------------------------------------
module bfgc_queue #(
  parameter int WIDTH = 51,
  parameter int DEPTH = bfgc_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] pop_data,
  output bfgc_pkg::q_stat_t     stat
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    store_r [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0] count_r, count_nxt;
  logic                do_push, do_pop;

  assign stat.full  = (count_r == CNT_BITS'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_data   = store_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ===== design/bfgc_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bfgc_back
// Memory access, hit test, lane and hit counters, and the output register.
// ----------------------------------------------------------------------------
module bfgc_back #(
  parameter int INDEX_BITS = bfgc_pkg::INDEX_BITS_DEF,
  parameter int MAX_BATCH  = bfgc_pkg::MAX_BATCH_DEF,
  parameter int Q_WIDTH    = INDEX_BITS + 35
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire bfgc_pkg::q_stat_t                    q_stat,
  input  wire logic [Q_WIDTH-1:0]                   q_data,
  output logic                                      q_pop,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic                                      out_kind,
  output logic [bfgc_pkg::LANE_OUT_BITS-1:0]        out_lane_index,
  output logic [bfgc_pkg::DATA_BITS-1:0]            out_entry_value,
  output logic [bfgc_pkg::HIT_BITS-1:0]             out_hit_total
);

  localparam int WORD_BITS   = INDEX_BITS - 5;
  localparam int WORD_DEPTH  = 1 << WORD_BITS;
  localparam int TABLE_DEPTH = 1 << INDEX_BITS;
  localparam int LANE_BITS   = $clog2(MAX_BATCH);
  localparam int DB          = bfgc_pkg::DATA_BITS;
  localparam int HB          = bfgc_pkg::HIT_BITS;
  localparam int LB          = bfgc_pkg::LANE_OUT_BITS;

  logic [DB-1:0] bmp_mem [WORD_DEPTH];
  logic [DB-1:0] tbl_mem [TABLE_DEPTH];

  logic [bfgc_pkg::OP_BITS-1:0] q_op;
  logic                         q_last;
  logic [DB-1:0]                q_wdata;
  logic [INDEX_BITS-1:0]        q_idx;

  logic          s1_r;
  logic [DB-1:0] bmp_rd_r;
  logic [DB-1:0] tbl_rd_r;
  logic [4:0]    bit_r;
  logic          last_r;

  logic [LANE_BITS-1:0] lane_r, lane_nxt;
  logic [HB-1:0]        hit_cnt_r, hit_cnt_nxt, hit_inc;
  logic                 sum_pend_r, sum_pend_nxt;
  logic [HB-1:0]        sum_total_r, sum_total_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic          out_kind_r, out_kind_nxt;
  logic [LB-1:0] out_lane_r, out_lane_nxt;
  logic [DB-1:0] out_entry_r, out_entry_nxt;
  logic [HB-1:0] out_total_r, out_total_nxt;

  logic out_free, s1_go, hit;
  logic [LANE_BITS+LB-1:0] lane_ext;

  assign {q_op, q_last, q_wdata, q_idx} = q_data;

  assign out_free = !out_valid_r || out_ready;
  assign s1_go    = s1_r && !sum_pend_r && out_free;
  assign q_pop    = !q_stat.empty && (!s1_r || s1_go);
  assign hit      = bmp_rd_r[bit_r];
  assign hit_inc  = (hit_cnt_r != bfgc_pkg::HIT_MAX) ? hit_cnt_r + 1'b1 : hit_cnt_r;
  assign lane_ext = {{LB{1'b0}}, lane_r};

  always_ff @(posedge clk) begin
    if (q_pop) begin
      if (q_op == bfgc_pkg::OP_WR_BMP) begin
        bmp_mem[q_idx[WORD_BITS-1:0]] <= q_wdata;
      end
      bmp_rd_r <= bmp_mem[q_idx[INDEX_BITS-1:5]];
      bit_r    <= q_idx[4:0];
      last_r   <= q_last;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      if (q_op == bfgc_pkg::OP_WR_TBL) begin
        tbl_mem[q_idx] <= q_wdata;
      end
      tbl_rd_r <= tbl_mem[q_idx];
    end
  end

  always_comb begin
    lane_nxt      = lane_r;
    hit_cnt_nxt   = hit_cnt_r;
    sum_pend_nxt  = sum_pend_r;
    sum_total_nxt = sum_total_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_kind_nxt  = out_kind_r;
    out_lane_nxt  = out_lane_r;
    out_entry_nxt = out_entry_r;
    out_total_nxt = out_total_r;
    if (sum_pend_r && out_free) begin
      sum_pend_nxt  = 1'b0;
      out_valid_nxt = 1'b1;
      out_kind_nxt  = bfgc_pkg::KIND_SUMMARY;
      out_lane_nxt  = '0;
      out_entry_nxt = '0;
      out_total_nxt = sum_total_r;
    end else if (s1_go) begin
      lane_nxt    = (lane_r == LANE_BITS'(MAX_BATCH - 1)) ? '0 : lane_r + 1'b1;
      hit_cnt_nxt = hit ? hit_inc : hit_cnt_r;
      if (hit) begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = bfgc_pkg::KIND_HIT;
        out_lane_nxt  = lane_ext[LB-1:0];
        out_entry_nxt = tbl_rd_r;
        out_total_nxt = '0;
        if (last_r) begin
          sum_pend_nxt  = 1'b1;
          sum_total_nxt = hit_inc;
        end
      end else if (last_r) begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = bfgc_pkg::KIND_SUMMARY;
        out_lane_nxt  = '0;
        out_entry_nxt = '0;
        out_total_nxt = hit_cnt_r;
      end
      if (last_r) begin
        lane_nxt    = '0;
        hit_cnt_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r        <= 1'b0;
      lane_r      <= '0;
      hit_cnt_r   <= '0;
      sum_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        s1_r <= (q_op == bfgc_pkg::OP_PROBE);
      end else if (s1_go) begin
        s1_r <= 1'b0;
      end
      lane_r      <= lane_nxt;
      hit_cnt_r   <= hit_cnt_nxt;
      sum_pend_r  <= sum_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_total_r <= sum_total_nxt;
    out_kind_r  <= out_kind_nxt;
    out_lane_r  <= out_lane_nxt;
    out_entry_r <= out_entry_nxt;
    out_total_r <= out_total_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_lane_index  = out_lane_r;
  assign out_entry_value = out_entry_r;
  assign out_hit_total   = out_total_r;

  a_pend_has_hit: assert property (@(posedge clk) disable iff (!rst_n)
    sum_pend_r |-> out_valid_r && out_kind_r == bfgc_pkg::KIND_HIT)
    else $error("summary pending without a hit beat in the output register");

  a_summary_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r == bfgc_pkg::KIND_SUMMARY |->
      out_lane_r == '0 && out_entry_r == '0)
    else $error("summary beat carries lane or entry data");

  a_hit_zero_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r == bfgc_pkg::KIND_HIT |-> out_total_r == '0)
    else $error("hit beat carries a hit total");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && last_r && !(sum_pend_r && out_free) |=> lane_r == '0 && hit_cnt_r == '0)
    else $error("counters not cleared after the last probe of a batch");

endmodule
`default_nettype wire

// ===== design/bitmap_filtered_gather_compact.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_filtered_gather_compact
// Bitmap membership filter with table gather and stream compaction.
// ----------------------------------------------------------------------------
// Path: input register, queue, memory read stage, then the output register.
// Throughput: one item per cycle unless out_ready stalls; a hitting last probe
// takes two output beats, set by the single output register of the back end.
// Reset: clears counters, queue and valid flags; bitmap and table memories
// are not cleared and hold undefined data until written.
// ----------------------------------------------------------------------------
module bitmap_filtered_gather_compact #(
  parameter int INDEX_BITS  = bfgc_pkg::INDEX_BITS_DEF,
  parameter int MAX_BATCH   = bfgc_pkg::MAX_BATCH_DEF,
  parameter int QUEUE_DEPTH = bfgc_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [bfgc_pkg::OP_BITS-1:0]         in_operation,
  input  wire logic [bfgc_pkg::IN_IDX_BITS-1:0]     in_index,
  input  wire logic [bfgc_pkg::DATA_BITS-1:0]       in_data,
  input  wire logic                                 in_last_in_batch,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic                                      out_kind,
  output logic [bfgc_pkg::LANE_OUT_BITS-1:0]        out_lane_index,
  output logic [bfgc_pkg::DATA_BITS-1:0]            out_entry_value,
  output logic [bfgc_pkg::HIT_BITS-1:0]             out_hit_total
);

  localparam int Q_WIDTH = INDEX_BITS + bfgc_pkg::OP_BITS + 1 + bfgc_pkg::DATA_BITS;

  bfgc_pkg::q_stat_t  q_stat;
  logic               q_push;
  logic               q_pop;
  logic [Q_WIDTH-1:0] q_push_data;
  logic [Q_WIDTH-1:0] q_pop_data;

  bfgc_front #(
    .INDEX_BITS (INDEX_BITS),
    .Q_WIDTH    (Q_WIDTH)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_index         (in_index),
    .in_data          (in_data),
    .in_last_in_batch (in_last_in_batch),
    .q_stat           (q_stat),
    .q_push           (q_push),
    .q_data           (q_push_data)
  );

  bfgc_queue #(
    .WIDTH (Q_WIDTH),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .stat      (q_stat)
  );

  bfgc_back #(
    .INDEX_BITS (INDEX_BITS),
    .MAX_BATCH  (MAX_BATCH),
    .Q_WIDTH    (Q_WIDTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_stat          (q_stat),
    .q_data          (q_pop_data),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_lane_index  (out_lane_index),
    .out_entry_value (out_entry_value),
    .out_hit_total   (out_hit_total)
  );

endmodule
`default_nettype wire
